FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked only while out of reset
`define QC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("qcsr assertion failed");
// Checked at every edge, reset included
`define QC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("qcsr assertion failed");
`else
`define QC_ASSERT(label, clk, rst_n, prop)
`define QC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

FILE: rtl/qcsr_pkg.sv
// ----------------------------------------------------------------------------
// qcsr_pkg
// Shared constants, codes and types of the quadrature counter block.
// ----------------------------------------------------------------------------
package qcsr_pkg;

  localparam int unsigned POS_WIDTH      = 16;
  localparam int unsigned COUNTS_PER_LED = 25;
  localparam int unsigned THR_WIDTH      = 16;
  localparam int unsigned STALL_WIDTH    = 8;
  localparam int unsigned RING_WIDTH     = 4;
  localparam int unsigned LED_WIDTH      = 8;
  localparam int unsigned FUNC_WIDTH     = 2;
  localparam int unsigned CFG_IDX_WIDTH  = 2;
  localparam int unsigned CFG_DATA_WIDTH = 16;

  localparam logic [THR_WIDTH-1:0]   REACH_THRESHOLD_RST = THR_WIDTH'(300);
  localparam logic [STALL_WIDTH-1:0] STALL_TICKS_RST     = STALL_WIDTH'(40);

  typedef enum logic [FUNC_WIDTH-1:0] {
    FUNC_EDGE_A = 2'd0,
    FUNC_EDGE_B = 2'd1,
    FUNC_TICK   = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_REACH_THRESHOLD = 2'd0,
    CFG_STALL_TICKS     = 2'd1,
    CFG_RING_DIRECTION  = 2'd2
  } cfg_idx_e;

  // Trailing zero count of a positive constant
  function automatic int unsigned tz_count(int unsigned d);
    int unsigned n;
    int unsigned v;
    n = 0;
    v = d;
    for (int i = 0; i < 32; i++) begin
      if (v != 0 && v[0] == 1'b0) begin
        v = v >> 1;
        n = n + 1;
      end
    end
    return n;
  endfunction

  // Multiplicative inverse of an odd constant modulo 2^32 (Newton steps)
  function automatic int unsigned odd_inverse(int unsigned o);
    int unsigned x;
    x = o;
    for (int i = 0; i < 5; i++) begin
      x = x * (32'd2 - o * x);
    end
    return x;
  endfunction

  // Divisibility by COUNTS_PER_LED: low zero bits plus odd-part inverse test
  localparam int unsigned CPL_SHIFT = tz_count(COUNTS_PER_LED);
  localparam int unsigned CPL_ODD   = COUNTS_PER_LED >> CPL_SHIFT;
  localparam logic [POS_WIDTH-1:0] CPL_INV   = POS_WIDTH'(odd_inverse(CPL_ODD));
  localparam logic [POS_WIDTH-1:0] CPL_LIMIT =
    POS_WIDTH'(((64'd1 << POS_WIDTH) - 64'd1) / CPL_ODD);
  localparam logic [POS_WIDTH-1:0] CPL_LOW_MASK =
    POS_WIDTH'((64'd1 << CPL_SHIFT) - 64'd1);

  typedef struct packed {
    logic signed [POS_WIDTH-1:0] position;
    logic                        reached;
    logic                        stopped;
    logic [LED_WIDTH-1:0]        led_onehot;
    logic                        bank_first;
    logic                        bank_second;
  } res_t;

endpackage

FILE: rtl/qcsr_in_if.sv
// ----------------------------------------------------------------------------
// qcsr_in_if
// Event request channel: edge or tick with channel levels and confirm.
// ----------------------------------------------------------------------------
interface qcsr_in_if;
  logic                                valid;
  logic                                ready;
  logic [qcsr_pkg::FUNC_WIDTH-1:0]     func;
  logic                                level_a;
  logic                                level_b;
  logic                                confirm;

  modport source (output valid, func, level_a, level_b, confirm, input ready);
  modport sink   (input valid, func, level_a, level_b, confirm, output ready);
endinterface

FILE: rtl/qcsr_out_if.sv
// ----------------------------------------------------------------------------
// qcsr_out_if
// Result request channel: position, flags and LED ring drive.
// ----------------------------------------------------------------------------
interface qcsr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qcsr_pkg::POS_WIDTH-1:0] position;
  logic                                 reached;
  logic                                 stopped;
  logic [qcsr_pkg::LED_WIDTH-1:0]       led_onehot;
  logic                                 bank_first;
  logic                                 bank_second;

  modport source (output valid, position, reached, stopped, led_onehot, bank_first,
                  bank_second, input ready);
  modport sink   (input valid, position, reached, stopped, led_onehot, bank_first,
                  bank_second, output ready);
endinterface

FILE: rtl/qcsr_cfg_if.sv
// ----------------------------------------------------------------------------
// qcsr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface qcsr_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [qcsr_pkg::CFG_IDX_WIDTH-1:0]    index;
  logic [qcsr_pkg::CFG_DATA_WIDTH-1:0]   wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

FILE: rtl/quadrature_counter_stall_ring.sv
// Results are registered into the result register, or into the skid while that is held.
// Throughput: one event request per cycle while the skid is empty; one logic pass from
// state into result register. A two-entry output buffer (result register plus skid)
//   keeps input taking one more request during output stall; ready drops only when both hold.
// Reset (rst_ni low, asynchronous): position, snapshot, counters, flags and
//   ring go to zero, registers to their defaults; no results pending.
// ----------------------------------------------------------------------------
// quadrature_counter_stall_ring
// x4 quadrature position counter with stall detect, reach flag and LED ring.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quadrature_counter_stall_ring (
  input  logic         clk_i,
  input  logic         rst_ni,
  qcsr_in_if.sink      in_i,
  qcsr_cfg_if.sink     cfg_i,
  qcsr_out_if.source   out_o
);

  localparam int unsigned PW = qcsr_pkg::POS_WIDTH;

  // Configuration registers
  logic [qcsr_pkg::THR_WIDTH-1:0]   reach_threshold_q;
  logic [qcsr_pkg::STALL_WIDTH-1:0] stall_ticks_q;
  logic                             ring_direction_q;

  // Counter state
  logic [PW-1:0]                    pos_q, pos_d;
  logic [PW-1:0]                    snap_q, snap_d;
  logic [qcsr_pkg::STALL_WIDTH-1:0] idle_q, idle_d;
  logic [PW-1:0]                    last_step_q, last_step_d;
  logic                             stop_q, stop_d;
  logic                             reach_q, reach_d;
  logic [qcsr_pkg::RING_WIDTH-1:0]  ring_q, ring_d;

  // Output buffer
  qcsr_pkg::res_t out_q, skid_q, res_d;
  logic           out_valid_q, skid_valid_q;

  logic acc, pop, cfg_acc;

  // Tick datapath helpers
  logic [PW-1:0]                    mag;
  logic [PW-1:0]                    mag_odd;
  logic [PW-1:0]                    inv_prod;
  logic                             div_hit;
  logic [qcsr_pkg::STALL_WIDTH-1:0] idle_inc;
  qcsr_pkg::func_e                  func;

  assign in_i.ready  = !skid_valid_q;
  assign cfg_i.ready = 1'b1;
  assign acc     = in_i.valid && in_i.ready;
  assign pop     = out_valid_q && out_o.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign func    = qcsr_pkg::func_e'(in_i.func);

  // Magnitude; the most negative value maps to 2^(PW-1) as unsigned
  assign mag      = pos_q[PW-1] ? (~pos_q + PW'(1)) : pos_q;
  assign mag_odd  = mag >> qcsr_pkg::CPL_SHIFT;
  // Exact multiple test: odd part times its inverse lands in the low range
  assign inv_prod = mag_odd * qcsr_pkg::CPL_INV;
  assign div_hit  = ((mag & qcsr_pkg::CPL_LOW_MASK) == '0) &&
                    (inv_prod <= qcsr_pkg::CPL_LIMIT);
  assign idle_inc = (pos_q == snap_q) ? idle_q + qcsr_pkg::STALL_WIDTH'(1) : '0;

  always_comb begin
    pos_d       = pos_q;
    snap_d      = snap_q;
    idle_d      = idle_q;
    last_step_d = last_step_q;
    stop_d      = stop_q;
    reach_d     = reach_q;
    ring_d      = ring_q;
    case (func)
      qcsr_pkg::FUNC_EDGE_A: begin
        // A edge: down when levels match
        pos_d  = (in_i.level_a == in_i.level_b) ? pos_q - PW'(1) : pos_q + PW'(1);
        stop_d = 1'b0;
      end
      qcsr_pkg::FUNC_EDGE_B: begin
        pos_d  = (in_i.level_a == in_i.level_b) ? pos_q + PW'(1) : pos_q - PW'(1);
        stop_d = 1'b0;
      end
      qcsr_pkg::FUNC_TICK: begin
        // Stall check runs on the updated idle count
        idle_d = idle_inc;
        if (idle_inc == stall_ticks_q) begin
          idle_d = '0;
          stop_d = 1'b1;
        end
        snap_d = pos_q;
        if (32'(reach_threshold_q) <= 32'(mag)) begin
          reach_d = 1'b1;
        end
        if (in_i.confirm) begin
          pos_d   = '0;
          reach_d = 1'b0;
        end
        // Ring: position after confirm is pos_q, or zero on confirm
        if (in_i.confirm || pos_q == '0) begin
          ring_d = '0;
        end else if (div_hit && last_step_q != pos_q) begin
          ring_d      = ring_direction_q ? ring_q - qcsr_pkg::RING_WIDTH'(1)
                                         : ring_q + qcsr_pkg::RING_WIDTH'(1);
          last_step_d = pos_q;
        end
      end
      default: begin
        // unused code: state holds, current state is reported
      end
    endcase

    res_d.position    = $signed(pos_d);
    res_d.reached     = reach_d;
    res_d.stopped     = stop_d;
    res_d.led_onehot  = qcsr_pkg::LED_WIDTH'(1) << ring_d[2:0];
    res_d.bank_first  = !ring_d[qcsr_pkg::RING_WIDTH-1];
    res_d.bank_second = ring_d[qcsr_pkg::RING_WIDTH-1];
  end

  // Configuration writes; an index past the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reach_threshold_q <= qcsr_pkg::REACH_THRESHOLD_RST;
      stall_ticks_q     <= qcsr_pkg::STALL_TICKS_RST;
      ring_direction_q  <= 1'b0;
    end else if (cfg_acc) begin
      case (qcsr_pkg::cfg_idx_e'(cfg_i.index))
        qcsr_pkg::CFG_REACH_THRESHOLD: begin
          reach_threshold_q <= cfg_i.wdata[qcsr_pkg::THR_WIDTH-1:0];
        end
        qcsr_pkg::CFG_STALL_TICKS: begin
          stall_ticks_q <= cfg_i.wdata[qcsr_pkg::STALL_WIDTH-1:0];
        end
        qcsr_pkg::CFG_RING_DIRECTION: begin
          ring_direction_q <= cfg_i.wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Counter state advances on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      snap_q      <= '0;
      idle_q      <= '0;
      last_step_q <= '0;
      stop_q      <= 1'b0;
      reach_q     <= 1'b0;
      ring_q      <= '0;
    end else if (acc) begin
      pos_q       <= pos_d;
      snap_q      <= snap_d;
      idle_q      <= idle_d;
      last_step_q <= last_step_d;
      stop_q      <= stop_d;
      reach_q     <= reach_d;
      ring_q      <= ring_d;
    end
  end

  // Output buffer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (!acc) begin
        out_valid_q <= 1'b0;
      end
    end else if (acc) begin
      if (!out_valid_q) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // Output buffer payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (acc) begin
        out_q <= res_d;
      end
    end else if (acc) begin
      if (!out_valid_q) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.position    = out_q.position;
  assign out_o.reached     = out_q.reached;
  assign out_o.stopped     = out_q.stopped;
  assign out_o.led_onehot  = out_q.led_onehot;
  assign out_o.bank_first  = out_q.bank_first;
  assign out_o.bank_second = out_q.bank_second;

  // A skid entry never exists without a result in front of it
  `QC_ASSERT_ALWAYS(a_skid_behind_out, clk_i, skid_valid_q |-> out_valid_q)
  // Position moves only on an accepted request
  `QC_ASSERT(a_pos_on_accept, clk_i, rst_ni, !acc |=> $stable(pos_q))
  // Stopped flag rises only on a tick
  `QC_ASSERT(a_stop_on_tick, clk_i, rst_ni,
    $rose(stop_q) |-> $past(acc && in_i.func == qcsr_pkg::FUNC_TICK))

endmodule
